FILE: sv/smlcrc_pkg.sv
// smlcrc_pkg: shared constants, types and crc-32 helper functions
// for the salted multi-lane crc-32 checker; no dependencies
package smlcrc_pkg;

    localparam logic [31:0] CRC_POLY           = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT           = 32'hFFFF_FFFF;
    localparam int          SALT_BYTES         = 4;
    localparam int          SALT_REGS          = 4;
    localparam int          CHECK_COUNT        = 4;
    localparam int          LANE_COUNT_DEFAULT = 4;
    localparam int          CRC_W              = 32;
    localparam int          BYTE_W             = 8;
    localparam int          APB_ADDR_W         = 4;
    localparam int          APB_DATA_W         = 32;

    typedef enum logic [1:0] {
        REG_SALT_LANE0 = 2'd0,
        REG_SALT_LANE1 = 2'd1,
        REG_SALT_LANE2 = 2'd2,
        REG_SALT_LANE3 = 2'd3
    } reg_index_t;

    // per-lane control from the top level
    typedef struct packed {
        logic step;     // absorb the staged byte this cycle
        logic fresh;    // image not open: start from the salted preload
        logic salt_we;  // salt register of this lane is written
    } lane_ctrl_t;

    // one byte through the reflected crc-32, one bit per iteration
    function automatic logic [CRC_W-1:0] crc_step_byte(input logic [CRC_W-1:0] rem,
                                                        input logic [BYTE_W-1:0] data);
        logic [CRC_W-1:0] r;
        r = rem ^ {{(CRC_W-BYTE_W){1'b0}}, data};
        for (int k = 0; k < BYTE_W; k++) begin
            r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
        end
        return r;
    endfunction

    // all-ones start, then the four salt bytes lowest first
    function automatic logic [CRC_W-1:0] crc32_salt(input logic [CRC_W-1:0] salt);
        logic [CRC_W-1:0] r;
        r = CRC_INIT;
        for (int b = 0; b < SALT_BYTES; b++) begin
            r = crc_step_byte(r, salt[b*BYTE_W +: BYTE_W]);
        end
        return r;
    endfunction

endpackage

FILE: sv/salted_multi_lane_crc32.sv
// salted_multi_lane_crc32: top level, apb salt registers, stream stages and lane array
// depends on smlcrc_pkg and smlcrc_lane
//
// usage: image bytes arrive on the s_ stream, one byte per transfer in s_tdata,
// with s_tlast on the last byte of an image. salts for lanes 0..3 are written
// over the apb port at byte addresses 0, 4, 8, 12 while the block is idle; a
// salt takes effect with the next image. each lane starts at all ones, absorbs
// its salt, then every image byte. the transfer carrying s_tlast yields one
// m_ transfer holding the four inverted lane values (check0 in the low bits);
// other bytes produce nothing.
// throughput: one byte per cycle outside a stall, set by the one-byte crc step per lane
// between the input register and the lane remainder / result registers.
// result path: a last byte passes the input register, then the result register, which
// drives m_tvalid.
// stall: the result register holds while m_tready is low; input bytes keep
// flowing until a second last byte meets the full result register, then
// s_tready drops until the result is taken.
// reset: salts clear to zero, no image is open, both stream stages are empty.
module salted_multi_lane_crc32 #(
    parameter int LANE_COUNT = smlcrc_pkg::LANE_COUNT_DEFAULT
) (
    input  logic                                          aclk,
    input  logic                                          aresetn,
    // apb configuration port
    input  logic                                          psel,
    input  logic                                          penable,
    input  logic                                          pwrite,
    input  logic [smlcrc_pkg::APB_ADDR_W-1:0]             paddr,
    input  logic [smlcrc_pkg::APB_DATA_W-1:0]             pwdata,
    output logic [smlcrc_pkg::APB_DATA_W-1:0]             prdata,
    output logic                                          pready,
    // image byte stream
    input  logic                                          s_tvalid,
    output logic                                          s_tready,
    input  logic [smlcrc_pkg::BYTE_W-1:0]                 s_tdata,  // [7:0] image_byte
    input  logic                                          s_tlast,  // is_final
    // result stream
    output logic                                          m_tvalid,
    input  logic                                          m_tready,
    // [31:0] check0, [63:32] check1, [95:64] check2, [127:96] check3
    output logic [smlcrc_pkg::CHECK_COUNT*smlcrc_pkg::CRC_W-1:0] m_tdata
);
    import smlcrc_pkg::*;

    localparam int OUT_W = CHECK_COUNT * CRC_W;

    logic [CRC_W-1:0]  salt_reg [SALT_REGS];
    reg_index_t        reg_index;
    logic              cfg_we;

    logic              in_valid_reg;
    logic [BYTE_W-1:0] in_byte_reg;
    logic              in_last_reg;
    logic              image_open_reg;
    logic              out_valid_reg;
    logic [OUT_W-1:0]  out_data_reg;
    logic [OUT_W-1:0]  out_data_next;
    logic              advance;

    logic [CRC_W-1:0]  rem_next [LANE_COUNT];

    // configuration port
    assign pready    = 1'b1;
    assign reg_index = reg_index_t'(paddr[APB_ADDR_W-1:2]);
    assign cfg_we    = psel & penable & pwrite & pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < SALT_REGS; i++) begin
                salt_reg[i] <= '0;
            end
        end else if (cfg_we) begin
            salt_reg[reg_index] <= pwdata;
        end
    end

    always_comb begin
        unique case (reg_index)
            REG_SALT_LANE0: prdata = salt_reg[REG_SALT_LANE0];
            REG_SALT_LANE1: prdata = salt_reg[REG_SALT_LANE1];
            REG_SALT_LANE2: prdata = salt_reg[REG_SALT_LANE2];
            REG_SALT_LANE3: prdata = salt_reg[REG_SALT_LANE3];
            default:        prdata = '0;
        endcase
    end

    // the staged byte moves on unless it closes an image and the result slot is blocked
    assign advance  = in_valid_reg & ~(in_last_reg & out_valid_reg & ~m_tready);
    assign s_tready = ~in_valid_reg | advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready & s_tvalid) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            image_open_reg <= 1'b0;
        end else if (advance) begin
            image_open_reg <= ~in_last_reg;
        end
    end

    // lane array
    for (genvar g = 0; g < LANE_COUNT; g++) begin : g_lane
        lane_ctrl_t       ctrl;
        logic [CRC_W-1:0] salt_wdata;

        if (g < SALT_REGS) begin : g_salted
            assign ctrl.salt_we = cfg_we && (reg_index == reg_index_t'(g));
            assign salt_wdata   = pwdata;
        end else begin : g_unsalted
            assign ctrl.salt_we = 1'b0;
            assign salt_wdata   = '0;
        end
        assign ctrl.step  = advance;
        assign ctrl.fresh = ~image_open_reg;

        smlcrc_lane u_lane (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .ctrl       (ctrl),
            .salt_wdata (salt_wdata),
            .image_byte (in_byte_reg),
            .rem_next   (rem_next[g])
        );
    end

    for (genvar c = 0; c < CHECK_COUNT; c++) begin : g_check
        if (c < LANE_COUNT) begin : g_live
            assign out_data_next[c*CRC_W +: CRC_W] = ~rem_next[c];
        end else begin : g_absent
            assign out_data_next[c*CRC_W +: CRC_W] = '0;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance & in_last_reg) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance & in_last_reg) begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

FILE: sv/smlcrc_lane.sv
// smlcrc_lane: one crc-32 lane with its salted preload value and running remainder
// depends on smlcrc_pkg
module smlcrc_lane (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  smlcrc_pkg::lane_ctrl_t        ctrl,
    input  logic [smlcrc_pkg::CRC_W-1:0]  salt_wdata,
    input  logic [smlcrc_pkg::BYTE_W-1:0] image_byte,
    output logic [smlcrc_pkg::CRC_W-1:0]  rem_next
);
    import smlcrc_pkg::*;

    logic [CRC_W-1:0] preload_reg;
    logic [CRC_W-1:0] rem_reg;
    logic [CRC_W-1:0] rem_base;

    // preload is folded at salt write time, so the byte path sees one byte step only
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            preload_reg <= crc32_salt('0);
        end else if (ctrl.salt_we) begin
            preload_reg <= crc32_salt(salt_wdata);
        end
    end

    assign rem_base = ctrl.fresh ? preload_reg : rem_reg;
    assign rem_next = crc_step_byte(rem_base, image_byte);

    always_ff @(posedge aclk) begin
        if (ctrl.step) begin
            rem_reg <= rem_next;
        end
    end

endmodule
